>>> rtl/core/ira_pkg.sv
// Shared types, constants and helpers for the radix ASCII converter.
`default_nettype none

package ira_pkg;

   localparam int MAG_W              = 64;
   localparam int DIGIT_W            = 6;
   localparam int CHAR_W             = 8;
   localparam int SIGN_W             = 2;
   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 6;
   localparam int DEFAULT_MAX_DIGITS = 64;

   // Bits of the quotient handled per cycle by the divider.
   localparam int STEP_BITS = 8;
   localparam int DIV_STEPS = MAG_W / STEP_BITS;
   localparam int STEP_CW   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [DIGIT_W-1:0] RADIX_LIMIT = 6'd36;
   localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [DIGIT_W-1:0] DECIMAL_TEN = 6'd10;

   localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;

   localparam logic [SIGN_W-1:0] SIGN_NONE  = 2'd0;
   localparam logic [SIGN_W-1:0] SIGN_PLUS  = 2'd1;
   localparam logic [SIGN_W-1:0] SIGN_MINUS = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_SIGN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPERCASE = 2'd2;

   typedef struct packed {
      logic [MAG_W-1:0]  magnitude;
      logic [SIGN_W-1:0] sign;
   } ira_item_type;

   // Clamp a raw radix write into the range 2..36.
   function automatic logic [DIGIT_W-1:0] clamp_radix(input logic [DIGIT_W-1:0] raw);
      logic [DIGIT_W-1:0] r;
      if (raw < RADIX_MIN) begin
         r = RADIX_MIN;
      end else if (raw > RADIX_LIMIT) begin
         r = RADIX_LIMIT;
      end else begin
         r = raw;
      end
      return r;
   endfunction

   // Map a digit value 0..35 to its ASCII character.
   function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
      logic [CHAR_W-1:0] c;
      if (d < DECIMAL_TEN) begin
         c = ASCII_ZERO + {2'b00, d};
      end else begin
         c = (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + {2'b00, d - DECIMAL_TEN};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/ira_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module ira_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/ira_front.sv
// Front end: accepts input words, resolves the sign and queues them.
`default_nettype none

module ira_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [ira_pkg::MAG_W-1:0]      req_magnitude,
   input  wire logic                           req_is_negative,
   input  wire logic                           show_sign,
   output logic                                item_valid,
   output ira_pkg::ira_item_type               item,
   input  wire logic                           item_pop
);

   import ira_pkg::*;

   ira_item_type          queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  push;
   logic                  pop;
   ira_item_type          new_item;

   assign req_stall  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != '0);
   assign pop        = item_pop && item_valid;
   assign item       = queue_ff[rd_ptr_ff];

   // Minus wins over plus; plus only when enabled.
   always_comb begin
      new_item.magnitude = req_magnitude;
      if (req_is_negative) begin
         new_item.sign = SIGN_MINUS;
      end else if (show_sign) begin
         new_item.sign = SIGN_PLUS;
      end else begin
         new_item.sign = SIGN_NONE;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QUEUE_PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QUEUE_PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/ira_back.sv
// Back end: iterative divider, digit store and MSB-first character output.
`default_nettype none

module ira_back #(
   parameter int MAX_DIGITS = ira_pkg::DEFAULT_MAX_DIGITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             item_valid,
   input  wire ira_pkg::ira_item_type            item,
   output logic                                  item_pop,
   input  wire logic [ira_pkg::DIGIT_W-1:0]      radix,
   input  wire logic                             uppercase,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [ira_pkg::CHAR_W-1:0]       rsp_digit_char,
   output logic      [ira_pkg::SIGN_W-1:0]       rsp_sign_before,
   output logic                                  rsp_last
);

   import ira_pkg::*;

   localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CW = $clog2(MAX_DIGITS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_SHOW = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [MAG_W-1:0]     quot_ff, quot_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [STEP_CW-1:0]   step_ff, step_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [SIGN_W-1:0]    sign_ff, sign_in;
   logic [AW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 first_ff, first_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic [SIGN_W-1:0]    sign_out_ff, sign_out_in;
   logic                 last_ff, last_in;

   logic [MAG_W-1:0]     quot_next;
   logic [DIGIT_W-1:0]   rem_next;
   logic [STEP_BITS-1:0] qbits;
   logic [CW-1:0]        count_inc;
   logic                 last_step;

   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [DIGIT_W-1:0]   ram_rd_data;

   // Restoring division of the top byte of the quotient by the radix.
   always_comb begin
      logic [DIGIT_W:0] t;
      logic [DIGIT_W-1:0] r;
      r = rem_ff;
      qbits = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         t = {r, quot_ff[MAG_W-1-i]};
         if (t >= {1'b0, radix}) begin
            t = t - {1'b0, radix};
            qbits[STEP_BITS-1-i] = 1'b1;
         end
         r = t[DIGIT_W-1:0];
      end
      rem_next  = r;
      quot_next = {quot_ff[MAG_W-STEP_BITS-1:0], qbits};
   end

   assign last_step = (step_ff == STEP_CW'(DIV_STEPS - 1));
   assign count_inc = count_ff + CW'(1);
   assign ram_wr_en = (state_ff == ST_DIV) && last_step;
   assign item_pop  = (state_ff == ST_IDLE) && item_valid;

   always_comb begin
      state_in    = state_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      count_in    = count_ff;
      sign_in     = sign_ff;
      rd_idx_in   = rd_idx_ff;
      first_in    = first_ff;
      char_in     = char_ff;
      sign_out_in = sign_out_ff;
      last_in     = last_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               quot_in  = item.magnitude;
               rem_in   = '0;
               step_in  = '0;
               count_in = '0;
               sign_in  = item.sign;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quot_in = quot_next;
            if (last_step) begin
               // Digit done: store it, then stop on a zero quotient or a full store.
               rem_in    = '0;
               step_in   = '0;
               count_in  = count_inc;
               rd_idx_in = count_ff[AW-1:0];
               if ((quot_next == '0) || (count_inc == CW'(MAX_DIGITS))) begin
                  first_in = 1'b1;
                  state_in = ST_READ;
               end
            end else begin
               rem_in  = rem_next;
               step_in = step_ff + STEP_CW'(1);
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            char_in     = digit_ascii(ram_rd_data, uppercase);
            sign_out_in = first_ff ? sign_ff : SIGN_NONE;
            last_in     = (rd_idx_ff == '0);
            state_in    = ST_SHOW;
         end
         ST_SHOW: begin
            if (!rsp_stall) begin
               first_in = 1'b0;
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in   = rd_idx_ff - AW'(1);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = rd_idx_ff - AW'(1);
                  state_in    = ST_WAIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      count_ff    <= count_in;
      sign_ff     <= sign_in;
      rd_idx_ff   <= rd_idx_in;
      first_ff    <= first_in;
      char_ff     <= char_in;
      sign_out_ff <= sign_out_in;
      last_ff     <= last_in;
   end

   ira_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAX_DIGITS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (rem_next),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid       = (state_ff == ST_SHOW);
   assign rsp_digit_char  = char_ff;
   assign rsp_sign_before = sign_out_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

>>> rtl/core/integer_to_radix_ascii.sv
// Top level of the binary to radix ASCII converter.
// Each digit takes one 64-bit quotient pass through the divider, 8 bits a cycle;
//   the stored digits are then read back and emitted MSB first, one per result word.
// The back end takes a new word only once the last one has been fully emitted.
// Reset (synchronous, active high): radix 10, no plus sign, lowercase; queue and
//   output empty. The digit store needs no clearing pass.
`default_nettype none

module integer_to_radix_ascii #(
   parameter int MAX_DIGITS = ira_pkg::DEFAULT_MAX_DIGITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Configuration write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ira_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ira_pkg::CSR_DATA_W-1:0]    csr_data,
   // Input words
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [ira_pkg::MAG_W-1:0]         req_magnitude,
   input  wire logic                              req_is_negative,
   // Result words, one per digit
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [ira_pkg::CHAR_W-1:0]        rsp_digit_char,
   output logic      [ira_pkg::SIGN_W-1:0]        rsp_sign_before,
   output logic                                   rsp_last
);

   import ira_pkg::*;

   // Configuration registers. The radix is clamped to 2..36 as it is written,
   // so the divider only ever sees a legal base.
   logic [DIGIT_W-1:0] radix_ff, radix_in;
   logic               show_sign_ff, show_sign_in;
   logic               uppercase_ff, uppercase_in;

   // Handshake between the front queue and the back end.
   logic               item_valid;
   ira_item_type       item;
   logic               item_pop;

   // Always take configuration writes; the user must write them only while idle, as the block does not enforce it.
   assign csr_ready = 1'b1;

   always_comb begin
      radix_in     = radix_ff;
      show_sign_in = show_sign_ff;
      uppercase_in = uppercase_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RADIX:     radix_in     = clamp_radix(csr_data);
            CSR_SHOW_SIGN: show_sign_in = csr_data[0];
            CSR_UPPERCASE: uppercase_in = csr_data[0];
            default: begin
               // Drop writes to unused indexes.
               radix_in = radix_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= RADIX_RESET;
         show_sign_ff <= 1'b0;
         uppercase_ff <= 1'b0;
      end else begin
         radix_ff     <= radix_in;
         show_sign_ff <= show_sign_in;
         uppercase_ff <= uppercase_in;
      end
   end

   // Front: accept a word, resolve its sign code, hold it in a two-entry queue
   // so the next word is taken while the back end is still emitting.
   ira_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_magnitude   (req_magnitude),
      .req_is_negative (req_is_negative),
      .show_sign       (show_sign_ff),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop)
   );

   // Back: divide repeatedly by the radix, store digits LSB first, then read
   // them back MSB first and present one character per result word.
   ira_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop),
      .radix           (radix_ff),
      .uppercase       (uppercase_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digit_char  (rsp_digit_char),
      .rsp_sign_before (rsp_sign_before),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire
